### sv/buddy_allocator_top_defines.svh
// assertion macros for the buddy allocator
`ifndef BUDDY_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_ALLOCATOR_TOP_DEFINES_SVH
// implication checked on every edge outside reset
`define BA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/ba_pkg.sv
//------------------------------------------------------------------------------
// ba_pkg
// shared constants for the buddy allocator
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package ba_pkg;
    localparam int PAGE_ORDER = 12;
    localparam int TOP_ORDER  = 20;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
endpackage

### sv/buddy_allocator_top.sv
//------------------------------------------------------------------------------
// buddy_allocator_top
// binary buddy allocator with per-order lifo free lists held in memories
//------------------------------------------------------------------------------
// One request in, one response out. Page tables (order, free flag, next and
// prev links) live in one synchronous memory with a registered read, driven by
// a sequencer. A new request is taken whenever the sequencer is idle, even while
// the previous response still waits in the output register. The time from
// acceptance to a valid response is set by how far the request walks: the
// orders searched, the unlinking of the source block, each split and each merge
// step. The longest allocation takes one page out of a whole free region, the
// longest free runs a full merge chain, and an oversized allocation searches
// every order and fails. After reset a clearing pass writes every page entry
// before the first request is taken.
`timescale 1ns / 1ps
`include "buddy_allocator_top_defines.svh"
module buddy_allocator_top
    import ba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] mode, [22:1] request_bytes, [30:23] block_page
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] granted_page, [8] success
    output logic [15:0] m_axis_tdata
);
    localparam int PB = TOP_ORDER - PAGE_ORDER;
    localparam int NPAGES = 1 << PB;
    localparam int LEVELS = PB + 1;
    localparam int LB = $clog2(LEVELS + 1);
    localparam int OW = 4;
    localparam logic [OW-1:0] BAD = 4'd15;
    localparam logic [PB:0] NIL = (PB + 1)'(NPAGES);

    typedef struct packed {
        logic [OW-1:0] ord;
        logic          fr;
        logic [PB:0]   nx;
        logic [PB:0]   pv;
    } t_ent;

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_FIND  = 14'b00000000000100,
        S_RDP   = 14'b00000000001000,
        S_PULL  = 14'b00000000010000,
        S_PV    = 14'b00000000100000,
        S_NX    = 14'b00000001000000,
        S_AFTER = 14'b00000010000000,
        S_PUSH  = 14'b00000100000000,
        S_PH    = 14'b00001000000000,
        S_FRD   = 14'b00010000000000,
        S_FCHK  = 14'b00100000000000,
        S_BRD   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_st;

    t_ent mem [NPAGES];
    t_ent r_rd;
    logic [PB-1:0] rd_a, wr_a;
    logic wr_en;
    t_ent wr_d;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_a] <= wr_d;
        r_rd <= mem[rd_a];
    end

    t_st r_st, n_st;
    logic [PB:0] r_head [LEVELS];
    logic [PB:0] n_head [LEVELS];
    logic r_mode, n_mode;
    logic [21:0] r_size, n_size;
    logic [PB-1:0] r_p, n_p, r_b, n_b;
    logic [LB-1:0] r_want, n_want, r_lvl, n_lvl;
    logic [PB:0] r_cnt, n_cnt;
    t_ent r_ent, n_ent;
    logic r_ovld, n_ovld, r_ok, n_ok;
    logic [7:0] r_gp, n_gp;
    logic r_rsp_ok, n_rsp_ok;
    logic [7:0] r_rsp_gp, n_rsp_gp;

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = {7'd0, r_rsp_ok, r_rsp_gp};

    function automatic logic [PB-1:0] bud(input logic [PB-1:0] p, input logic [LB-1:0] l);
        bud = p ^ PB'((PB+1)'(1) << l);
    endfunction

    always_comb begin
        n_st = r_st; n_mode = r_mode; n_size = r_size; n_p = r_p; n_b = r_b;
        n_want = r_want; n_lvl = r_lvl; n_cnt = r_cnt; n_ent = r_ent;
        n_ovld = r_ovld; n_ok = r_ok; n_gp = r_gp;
        n_rsp_ok = r_rsp_ok; n_rsp_gp = r_rsp_gp;
        n_head = r_head;
        rd_a = r_p; wr_en = 1'b0; wr_a = r_p;
        wr_d = '{ord: BAD, fr: 1'b0, nx: NIL, pv: NIL};
        if (r_ovld && m_axis_tready) n_ovld = 1'b0;
        unique case (r_st)
            S_CLR: begin
                wr_en = 1'b1; wr_a = r_cnt[PB-1:0];
                if (r_cnt == '0) wr_d = '{ord: BAD, fr: 1'b1, nx: NIL, pv: NIL};
                if (r_cnt == (PB+1)'(NPAGES - 1)) n_st = S_IDLE;
                n_cnt = r_cnt + 1'b1;
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_mode = s_axis_tdata[0];
                    n_size = s_axis_tdata[22:1];
                    n_p = s_axis_tdata[PB+22:23];
                    n_ok = 1'b0; n_gp = '0; n_lvl = '0; n_cnt = '0;
                    n_st = (s_axis_tdata[0] == MODE_FREE) ? S_FRD : S_FIND;
                end
            end
            S_FIND: begin
                // one order a cycle: first fitting order, then first non-empty list
                if (r_lvl == LB'(LEVELS)) n_st = S_OUT;
                else if ((23'(1) << (5'(r_lvl) + 5'(PAGE_ORDER))) < {1'b0, r_size})
                    n_lvl = r_lvl + 1'b1;
                else begin
                    n_want = r_lvl;
                    n_st = S_RDP;
                end
            end
            S_RDP: begin
                if (r_lvl == LB'(LEVELS)) n_st = S_OUT;
                else if (r_head[r_lvl] == NIL) n_lvl = r_lvl + 1'b1;
                else begin
                    n_p = r_head[r_lvl][PB-1:0];
                    n_b = r_head[r_lvl][PB-1:0];
                    rd_a = r_head[r_lvl][PB-1:0];
                    n_st = S_PULL;
                end
            end
            S_PULL: begin
                // r_rd holds entry r_b; unlink it
                n_ent = r_rd;
                wr_en = 1'b1; wr_a = r_b;
                wr_d = '{ord: r_rd.ord, fr: 1'b0, nx: NIL, pv: NIL};
                if (r_rd.pv == NIL) n_head[r_lvl] = r_rd.nx;
                rd_a = r_rd.pv[PB-1:0];
                n_st = S_PV;
            end
            S_PV: begin
                if (r_ent.pv != NIL) begin
                    wr_en = 1'b1; wr_a = r_ent.pv[PB-1:0];
                    wr_d = r_rd; wr_d.nx = r_ent.nx;
                end
                rd_a = r_ent.nx[PB-1:0];
                n_st = S_NX;
            end
            S_NX: begin
                if (r_ent.nx != NIL) begin
                    wr_en = 1'b1; wr_a = r_ent.nx[PB-1:0];
                    wr_d = r_rd; wr_d.pv = r_ent.pv;
                end
                n_st = S_AFTER;
            end
            S_AFTER: begin
                if (r_mode == MODE_ALLOC) begin
                    if (r_lvl > r_want) begin
                        n_lvl = r_lvl - 1'b1;
                        n_b = bud(r_p, r_lvl - 1'b1);
                        rd_a = r_head[r_lvl - 1'b1][PB-1:0];
                        n_st = S_PUSH;
                    end else begin
                        wr_en = 1'b1; wr_a = r_p;
                        wr_d = '{ord: OW'(r_want), fr: 1'b0, nx: NIL, pv: NIL};
                        n_ok = 1'b1; n_gp = 8'(r_p);
                        n_st = S_OUT;
                    end
                end else begin
                    // merged: upper page loses its order
                    wr_en = 1'b1;
                    wr_a = (r_b > r_p) ? r_b : r_p;
                    wr_d = '{ord: BAD, fr: 1'b0, nx: NIL, pv: NIL};
                    n_p = (r_b < r_p) ? r_b : r_p;
                    n_lvl = r_lvl + 1'b1;
                    n_st = S_FCHK;
                    n_cnt = '0;
                end
            end
            S_PUSH: begin
                // push r_b at r_lvl; r_rd holds old head entry
                wr_en = 1'b1; wr_a = r_b;
                wr_d = '{ord: OW'(r_lvl), fr: 1'b1, nx: r_head[r_lvl], pv: NIL};
                n_head[r_lvl] = {1'b0, r_b};
                n_ent = r_rd;
                n_cnt = r_head[r_lvl];
                n_st = S_PH;
            end
            S_PH: begin
                if (r_cnt != NIL) begin
                    wr_en = 1'b1; wr_a = r_cnt[PB-1:0];
                    wr_d = r_ent; wr_d.pv = {1'b0, r_b};
                end
                if (r_mode == MODE_FREE) begin
                    n_ok = 1'b1; n_st = S_OUT;
                end else n_st = S_AFTER;
            end
            S_FRD: n_st = S_FCHK;
            S_FCHK: begin
                if (r_cnt == '0 && r_lvl == '0) begin
                    // first look at the freed page itself
                    if (r_rd.ord >= OW'(LEVELS) || r_rd.fr) n_st = S_OUT;
                    else begin
                        n_lvl = LB'(r_rd.ord);
                        n_cnt = (PB+1)'(1);
                        n_b = bud(r_p, LB'(r_rd.ord));
                        rd_a = bud(r_p, LB'(r_rd.ord));
                        n_st = (LB'(r_rd.ord) + 1'b1 < LB'(LEVELS)) ? S_BRD : S_PUSH;
                        if (n_st == S_PUSH) begin
                            n_b = r_p; rd_a = r_head[LB'(r_rd.ord)][PB-1:0];
                        end
                    end
                end else if (r_lvl + 1'b1 < LB'(LEVELS)) begin
                    n_cnt = (PB+1)'(1);
                    n_b = bud(r_p, r_lvl);
                    rd_a = bud(r_p, r_lvl);
                    n_st = S_BRD;
                end else begin
                    n_b = r_p; rd_a = r_head[r_lvl][PB-1:0];
                    n_st = S_PUSH;
                end
            end
            S_BRD: begin
                if (r_rd.ord == OW'(r_lvl) && r_rd.fr) begin
                    n_ent = r_rd;
                    wr_en = 1'b1; wr_a = r_b;
                    wr_d = '{ord: r_rd.ord, fr: 1'b0, nx: NIL, pv: NIL};
                    if (r_rd.pv == NIL) n_head[r_lvl] = r_rd.nx;
                    rd_a = r_rd.pv[PB-1:0];
                    n_st = S_PV;
                end else begin
                    n_b = r_p; rd_a = r_head[r_lvl][PB-1:0];
                    n_st = S_PUSH;
                end
            end
            S_OUT: begin
                // waits only while the previous response is still held
                if (!r_ovld || m_axis_tready) begin
                    n_ovld = 1'b1; n_rsp_ok = r_ok; n_rsp_gp = r_gp;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_cnt <= '0; r_ovld <= 1'b0;
            for (int i = 0; i < LEVELS; i++) r_head[i] <= (i == LEVELS - 1) ? '0 : NIL;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ovld <= n_ovld;
            r_head <= n_head;
        end
        r_mode <= n_mode; r_size <= n_size; r_p <= n_p; r_b <= n_b;
        r_want <= n_want; r_lvl <= n_lvl; r_ent <= n_ent;
        r_ok <= n_ok; r_gp <= n_gp;
        r_rsp_ok <= n_rsp_ok; r_rsp_gp <= n_rsp_gp;
    end

    `BA_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_st == S_IDLE,
        "ready outside idle")
    `BA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[8],
        m_axis_tdata[7:0] == 8'd0, "failed response with page")
    `BA_ASSERT_NEXT(a_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        r_st != S_IDLE, "request not taken")
endmodule

### bench/buddy_allocator_checker.sv
//------------------------------------------------------------------------------
// buddy_allocator_checker
// watches both streams, predicts each response and compares field by field
//------------------------------------------------------------------------------
// Keeps its own copy of the page tables and free lists. Every accepted request
// is run through the prediction at once; responses are compared in order
// against the queue of expected grants.
`timescale 1ns / 1ps
module buddy_allocator_checker
    import ba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [15:0] i_rsp_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_grants,
    output int          o_frees
);
    localparam int NUM_PAGES  = 1 << (TOP_ORDER - PAGE_ORDER);
    localparam int NUM_ORDERS = TOP_ORDER - PAGE_ORDER + 1;
    localparam int NONE       = NUM_PAGES;
    localparam logic [3:0] NO_ORDER = 4'd15;

    // ok sits above page, as on the response bus
    typedef struct packed {
        logic       ok;
        logic [7:0] page;
    } t_grant;

    logic [3:0] blk_order [NUM_PAGES];
    logic       is_free   [NUM_PAGES];
    int         fwd       [NUM_PAGES];
    int         bwd       [NUM_PAGES];
    int         heads     [NUM_ORDERS];
    t_grant     grant_q   [$];

    function automatic void list_push(int p, int o);
        bwd[p] = NONE;
        fwd[p] = heads[o];
        if (heads[o] < NONE) bwd[heads[o]] = p;
        heads[o] = p;
        is_free[p] = 1'b1;
    endfunction

    function automatic void list_pull(int p, int o);
        int n;
        int v;
        n = fwd[p];
        v = bwd[p];
        if (v < NONE) fwd[v] = n;
        else heads[o] = n;
        if (n < NONE) bwd[n] = v;
        fwd[p] = NONE;
        bwd[p] = NONE;
        is_free[p] = 1'b0;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < NUM_PAGES; i++) begin
            blk_order[i] = NO_ORDER;
            is_free[i] = 1'b0;
            fwd[i] = NONE;
            bwd[i] = NONE;
        end
        for (int i = 0; i < NUM_ORDERS; i++) heads[i] = NONE;
        list_push(0, NUM_ORDERS - 1);
    endfunction

    function automatic t_grant serve_request(logic [31:0] d);
        t_grant     g;
        logic       mode;
        logic [21:0] bytes;
        int         want;
        int         src;
        int         p;
        int         b;
        int         o;
        g = '0;
        mode = d[0];
        bytes = d[22:1];
        if (mode == MODE_ALLOC) begin
            want = NUM_ORDERS;
            for (int l = 0; l < NUM_ORDERS; l++)
                if (want == NUM_ORDERS && (64'd1 << (l + PAGE_ORDER)) >= bytes) want = l;
            if (want == NUM_ORDERS) return g;
            src = NUM_ORDERS;
            for (int l = want; l < NUM_ORDERS; l++)
                if (src == NUM_ORDERS && heads[l] < NONE) src = l;
            if (src == NUM_ORDERS) return g;
            p = heads[src];
            list_pull(p, src);
            while (src > want) begin
                src--;
                b = (p ^ (1 << src)) & (NUM_PAGES - 1);
                blk_order[b] = src[3:0];
                list_push(b, src);
            end
            blk_order[p] = want[3:0];
            g.page = p[7:0];
            g.ok = 1'b1;
        end else begin
            p = d[30:23];
            o = blk_order[p];
            if (o >= NUM_ORDERS || is_free[p]) return g;
            while (o + 1 < NUM_ORDERS) begin
                b = (p ^ (1 << o)) & (NUM_PAGES - 1);
                if (blk_order[b] != o || !is_free[b]) break;
                list_pull(b, o);
                blk_order[b < p ? p : b] = NO_ORDER;
                p = b < p ? b : p;
                o++;
            end
            blk_order[p] = o[3:0];
            list_push(p, o);
            g.ok = 1'b1;
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want_g;
        t_grant got_g;
        if (!i_rst_n) begin
            clear_tables();
            grant_q.delete();
            o_fail_count = 0;
            o_grants = 0;
            o_frees = 0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                want_g = serve_request(i_req_data);
                grant_q.push_back(want_g);
                if (want_g.ok && i_req_data[0] == MODE_ALLOC) o_grants++;
                if (want_g.ok && i_req_data[0] == MODE_FREE) o_frees++;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got_g = i_rsp_data[8:0];
                if (grant_q.size() == 0) begin
                    $error("response with nothing outstanding: data %h", i_rsp_data);
                    o_fail_count++;
                end else begin
                    want_g = grant_q.pop_front();
                    if (got_g.page !== want_g.page) begin
                        $error("granted_page expected %0d actual %0d", want_g.page, got_g.page);
                        o_fail_count++;
                    end
                    if (got_g.ok !== want_g.ok) begin
                        $error("success expected %0d actual %0d", want_g.ok, got_g.ok);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = grant_q.size();
    end
endmodule

### bench/tb_buddy_allocator_top.sv
//------------------------------------------------------------------------------
// tb_buddy_allocator_top
// stimulus and verdict for the buddy allocator
//------------------------------------------------------------------------------
// Directed requests cover size extremes, exhausting the region and every free
// case; the random part runs alloc/free sequences that mostly free blocks
// actually held, with some bogus and double frees mixed in.
`timescale 1ns / 1ps
module tb_buddy_allocator_top;
    import ba_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [31:0] req_data = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [15:0] rsp_data;
    int          fail_count;
    int          pending;
    int          grants;
    int          frees;
    int          sent = 0;
    bit          quiet = 1'b0;
    logic [7:0]  held [$];
    logic        mode_q [$];

    always #10 i_clk = ~i_clk;

    buddy_allocator_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(req_valid),
        .s_axis_tready(req_ready),
        .s_axis_tdata (req_data),
        .m_axis_tvalid(rsp_valid),
        .m_axis_tready(rsp_ready),
        .m_axis_tdata (rsp_data)
    );

    buddy_allocator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req_data  (req_data),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_rsp_data  (rsp_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_grants    (grants),
        .o_frees     (frees)
    );

    // pages granted by allocations, so frees can target real blocks
    always @(posedge i_clk) begin
        logic m;
        if (rsp_valid && rsp_ready && mode_q.size() != 0) begin
            m = mode_q.pop_front();
            if (m == MODE_ALLOC && rsp_data[8]) held.push_back(rsp_data[7:0]);
        end
    end

    // response side back-pressure in bursts
    always @(posedge i_clk) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        rsp_ready <= 1'b1;
    end

    // one request, optional idle burst before it
    task automatic send_request(logic mode, logic [21:0] bytes, logic [7:0] page);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_data <= {1'b0, page, bytes, mode};
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        sent++;
        mode_q.push_back(mode);
        // valid stays up until the next request or a drain replaces it
    endtask

    task automatic do_alloc(logic [21:0] bytes);
        send_request(MODE_ALLOC, bytes, 8'($urandom));
    endtask

    task automatic do_free(logic [7:0] page);
        send_request(MODE_FREE, 22'($urandom), page);
    endtask

    function automatic logic [21:0] pick_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 22'($urandom_range(0, 32768));
        if (sel < 8) return 22'($urandom_range(0, 1048576));
        if (sel < 9) return 22'(1 << $urandom_range(12, 20));
        return 22'($urandom);
    endfunction

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int idx;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, exhaustion and free special cases
        do_alloc(22'd1048576);
        do_alloc(22'd0);
        do_free(8'd0);
        do_alloc(22'd1048577);
        do_alloc(22'h3FFFFF);
        do_alloc(22'd4097);
        do_alloc(22'd0);
        do_alloc(22'd4096);
        do_free(8'd3);
        do_free(8'd3);
        do_free(8'd255);
        do_free(8'd128);
        do_alloc(22'd524288);
        do_alloc(22'd524288);
        do_alloc(22'd1);
        do_free(8'd0);
        do_free(8'd128);
        do_free(8'd2);
        do_free(8'd0);
        do_alloc(22'd2097152);
        do_alloc(22'd12288);
        do_alloc(22'd65536);
        drain();
        held.delete();
        // random alloc/free mix, last stretch without random idle or back-pressure bursts
        for (int n = 0; n < 1850; n++) begin
            if (n == 1600) quiet = 1'b1;
            if (n % 40 == 39) begin
                drain();
            end
            if (held.size() != 0 && $urandom_range(0, 9) < 5) begin
                drain();
                idx = $urandom_range(0, held.size() - 1);
                do_free(held[idx]);
                held.delete(idx);
            end else if ($urandom_range(0, 9) == 0) begin
                do_free(8'($urandom));
            end else begin
                do_alloc(pick_size());
            end
        end
        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests: %0d grants, %0d completed frees",
                 sent, grants, frees);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
